// ===== rtl/core/kw1281_block_link_unit_assert.svh =====
// ----------------------------------------------------------------------------
// kw1281_block_link_unit_assert.svh
// Assertion macros used by the block link checker.
// ----------------------------------------------------------------------------
`ifndef KW1281_BLOCK_LINK_UNIT_ASSERT_SVH
`define KW1281_BLOCK_LINK_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge, off during reset
`define KBL_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("kbl assertion failed (same cycle)");

// Next-cycle implication, sampled on the rising edge, off during reset
`define KBL_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("kbl assertion failed (next cycle)");

`endif

// ===== rtl/core/kbl_pkg.sv =====
// ----------------------------------------------------------------------------
// kbl_pkg
// Types, codes and constants of the KW1281 block link engine.
// ----------------------------------------------------------------------------
`default_nettype none

package kbl_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BLOCK_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_END_BYTE      = 1'b1;

  // Reset values of the registers
  localparam logic [BYTE_W-1:0] MAX_BLOCK_LEN_RST = 8'd64;
  localparam logic [BYTE_W-1:0] END_BYTE_RST      = 8'd3;

  // Protocol constants
  localparam logic [BYTE_W-1:0] SYNC_BYTE_0 = 8'h55;
  localparam logic [BYTE_W-1:0] SYNC_BYTE_1 = 8'h01;
  localparam logic [BYTE_W-1:0] SYNC_BYTE_2 = 8'h8A;
  localparam logic [BYTE_W-1:0] INV_MASK    = 8'hFF;
  localparam logic [BYTE_W-1:0] MIN_LEN     = 8'd3;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_RX    = 2'd1,
    REQ_TX    = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SYNC   = 3'd1,
    PH_READY  = 3'd2,
    PH_RX     = 3'd3,
    PH_TXWAIT = 3'd4,
    PH_TXHOST = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    FLD_NONE  = 3'd0,
    FLD_LEN   = 3'd1,
    FLD_CNT   = 3'd2,
    FLD_TITLE = 3'd3,
    FLD_DATA  = 3'd4
  } field_t;

  typedef enum logic [3:0] {
    ST_BUSY       = 4'd0,
    ST_SYNC_OK    = 4'd1,
    ST_RECEIVED   = 4'd2,
    ST_SENT       = 4'd3,
    ST_BAD_SYNC   = 4'd4,
    ST_TOO_LONG   = 4'd5,
    ST_BAD_CNT    = 4'd6,
    ST_BAD_END    = 4'd7,
    ST_BAD_COMPL  = 4'd8,
    ST_UNEXPECTED = 4'd9
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] max_block_len;
    logic [BYTE_W-1:0] end_byte;
  } cfg_t;

  typedef struct packed {
    req_t              req_type;
    logic [BYTE_W-1:0] rx_byte;
    logic [BYTE_W-1:0] tx_byte;
  } item_t;

  typedef struct packed {
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_out;
    field_t            rx_field;
    logic [BYTE_W-1:0] rx_value;
    status_t           status;
  } result_t;

  // Expected sync byte at a given position; position 3 never matches
  function automatic logic sync_match(input logic [1:0] pos, input logic [BYTE_W-1:0] b);
    logic hit;
    case (pos)
      2'd0:    hit = (b == SYNC_BYTE_0);
      2'd1:    hit = (b == SYNC_BYTE_1);
      2'd2:    hit = (b == SYNC_BYTE_2);
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/kw1281_block_link_unit.sv =====
// ----------------------------------------------------------------------------
// kw1281_block_link_unit
// KW1281 block link engine: sync, block receive with complement acks,
// block send with counter insertion and complement checks.
//
//   port group | direction | contents
//   s_*        | in        | one link event: request kind and bytes
//   m_*        | out       | one result per event
//   cfg_*      | in        | register writes (length limit, end byte)
//
// One beat in, one result out, one beat per cycle sustained while m_tready is high.
// The result is registered: the step logic sits between the input port and
// the result register. s_tready is high while the result register is empty
// or being taken, so a stalled m_tready holds one result and then stalls s.
// rst is synchronous; after it the link is idle with registers at defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module kw1281_block_link_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // slave side
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [15:0]                          s_tdata,  // rx_byte, tx_byte
  input  wire logic [1:0]                           s_tuser,  // req_type
  // master side
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic [23:0]                               m_tdata,  // tx_valid, tx_out, rx_value, pad
  output logic [6:0]                                m_tuser,  // rx_field, status
  // configuration
  input  wire logic                                 cfg_we,
  input  wire logic [kbl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [kbl_pkg::BYTE_W-1:0]           cfg_data
);

  kbl_pkg::cfg_t    cfg;
  kbl_pkg::item_t   item;
  kbl_pkg::result_t result;
  kbl_pkg::result_t held;
  logic             accept;

  // Handshake
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Unpack the input beat
  assign item.req_type = kbl_pkg::req_t'(s_tuser);
  assign item.rx_byte  = s_tdata[7:0];
  assign item.tx_byte  = s_tdata[15:8];

  kbl_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kbl_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  kbl_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .result (result),
    .full   (m_tvalid),
    .take   (m_tready),
    .held   (held)
  );

  // Pack the result beat
  assign m_tdata = {7'd0, held.rx_value, held.tx_out, held.tx_valid};
  assign m_tuser = {held.status, held.rx_field};

endmodule

`default_nettype wire

// ===== rtl/core/kbl_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// kbl_cfg_regs
// Configuration registers: block length limit and end byte.
// ----------------------------------------------------------------------------
`default_nettype none

module kbl_cfg_regs (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [kbl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [kbl_pkg::BYTE_W-1:0]           cfg_data,
  output kbl_pkg::cfg_t                             cfg
);

  // Register writes, one per enabled cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_block_len <= kbl_pkg::MAX_BLOCK_LEN_RST;
      cfg.end_byte      <= kbl_pkg::END_BYTE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        kbl_pkg::REG_MAX_BLOCK_LEN: cfg.max_block_len <= cfg_data;
        kbl_pkg::REG_END_BYTE:      cfg.end_byte      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/kbl_engine.sv =====
// ----------------------------------------------------------------------------
// kbl_engine
// Link state and the per-byte step: next state and result of one item.
// ----------------------------------------------------------------------------
`default_nettype none

module kbl_engine (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire kbl_pkg::item_t  item,
  input  wire kbl_pkg::cfg_t   cfg,
  output kbl_pkg::result_t result
);

  kbl_pkg::phase_t              phase, phase_next;
  logic [1:0]                   sync_position, sync_position_next;
  logic [kbl_pkg::BYTE_W-1:0]   block_count, block_count_next;
  logic [kbl_pkg::BYTE_W-1:0]   byte_position, byte_position_next;
  logic [kbl_pkg::BYTE_W-1:0]   block_length, block_length_next;
  logic [kbl_pkg::BYTE_W-1:0]   expected_reply, expected_reply_next;

  logic [kbl_pkg::BYTE_W-1:0]   eff_len;
  logic [kbl_pkg::BYTE_W-1:0]   count_inc;
  logic [kbl_pkg::BYTE_W-1:0]   rx_inv;
  logic [kbl_pkg::BYTE_W-1:0]   send_byte;

  assign eff_len   = (block_length < kbl_pkg::MIN_LEN) ? kbl_pkg::MIN_LEN : block_length;
  assign count_inc = block_count + 8'd1;
  assign rx_inv    = item.rx_byte ^ kbl_pkg::INV_MASK;
  // counter goes into slot 1 of a sent block
  assign send_byte = (byte_position == 8'd1) ? block_count : item.tx_byte;

  // Step logic
  always_comb begin
    phase_next          = phase;
    sync_position_next  = sync_position;
    block_count_next    = block_count;
    byte_position_next  = byte_position;
    block_length_next   = block_length;
    expected_reply_next = expected_reply;

    result          = '0;
    result.rx_field = kbl_pkg::FLD_NONE;
    result.status   = kbl_pkg::ST_UNEXPECTED;

    case (item.req_type)
      kbl_pkg::REQ_START: begin
        block_count_next   = '0;
        sync_position_next = '0;
        phase_next         = kbl_pkg::PH_SYNC;
        result.status      = kbl_pkg::ST_BUSY;
      end

      kbl_pkg::REQ_RX: begin
        case (phase)
          kbl_pkg::PH_SYNC: begin
            if (!kbl_pkg::sync_match(sync_position, item.rx_byte)) begin
              result.status = kbl_pkg::ST_BAD_SYNC;
              phase_next    = kbl_pkg::PH_IDLE;
            end else if (sync_position != 2'd2) begin
              sync_position_next = sync_position + 2'd1;
              result.status      = kbl_pkg::ST_BUSY;
            end else begin
              result.tx_valid = 1'b1;
              result.tx_out   = rx_inv;
              result.status   = kbl_pkg::ST_SYNC_OK;
              phase_next      = kbl_pkg::PH_READY;
            end
          end

          // first byte of a received block is its length
          kbl_pkg::PH_READY: begin
            if (item.rx_byte > cfg.max_block_len) begin
              result.status = kbl_pkg::ST_TOO_LONG;
              phase_next    = kbl_pkg::PH_IDLE;
            end else begin
              result.tx_valid    = 1'b1;
              result.tx_out      = rx_inv;
              result.rx_field    = kbl_pkg::FLD_LEN;
              result.rx_value    = item.rx_byte;
              result.status      = kbl_pkg::ST_BUSY;
              block_length_next  = item.rx_byte;
              byte_position_next = 8'd1;
              phase_next         = kbl_pkg::PH_RX;
            end
          end

          kbl_pkg::PH_RX: begin
            if (byte_position == 8'd1) begin
              // counter: complement is sent even on mismatch
              result.tx_valid  = 1'b1;
              result.tx_out    = rx_inv;
              block_count_next = count_inc;
              if (item.rx_byte != count_inc) begin
                result.status = kbl_pkg::ST_BAD_CNT;
                phase_next    = kbl_pkg::PH_IDLE;
              end else begin
                result.rx_field    = kbl_pkg::FLD_CNT;
                result.rx_value    = item.rx_byte;
                result.status      = kbl_pkg::ST_BUSY;
                byte_position_next = 8'd2;
              end
            end else if (byte_position == 8'd2) begin
              result.tx_valid    = 1'b1;
              result.tx_out      = rx_inv;
              result.rx_field    = kbl_pkg::FLD_TITLE;
              result.rx_value    = item.rx_byte;
              result.status      = kbl_pkg::ST_BUSY;
              byte_position_next = 8'd3;
            end else if (byte_position < eff_len) begin
              result.tx_valid    = 1'b1;
              result.tx_out      = rx_inv;
              result.rx_field    = kbl_pkg::FLD_DATA;
              result.rx_value    = item.rx_byte;
              result.status      = kbl_pkg::ST_BUSY;
              byte_position_next = byte_position + 8'd1;
            end else if (item.rx_byte == cfg.end_byte) begin
              result.status = kbl_pkg::ST_RECEIVED;
              phase_next    = kbl_pkg::PH_READY;
            end else begin
              result.status = kbl_pkg::ST_BAD_END;
              phase_next    = kbl_pkg::PH_IDLE;
            end
          end

          // partner's complement of our last byte
          kbl_pkg::PH_TXWAIT: begin
            if (item.rx_byte != expected_reply) begin
              result.status = kbl_pkg::ST_BAD_COMPL;
              phase_next    = kbl_pkg::PH_IDLE;
            end else if (byte_position >= eff_len) begin
              result.tx_valid = 1'b1;
              result.tx_out   = cfg.end_byte;
              result.status   = kbl_pkg::ST_SENT;
              phase_next      = kbl_pkg::PH_READY;
            end else begin
              result.status = kbl_pkg::ST_BUSY;
              phase_next    = kbl_pkg::PH_TXHOST;
            end
          end

          default: ;
        endcase
      end

      kbl_pkg::REQ_TX: begin
        case (phase)
          // host length byte opens a send block
          kbl_pkg::PH_READY: begin
            block_count_next = count_inc;
            if (item.tx_byte > cfg.max_block_len) begin
              result.status = kbl_pkg::ST_TOO_LONG;
              phase_next    = kbl_pkg::PH_IDLE;
            end else begin
              result.tx_valid     = 1'b1;
              result.tx_out       = item.tx_byte;
              result.status       = kbl_pkg::ST_BUSY;
              block_length_next   = item.tx_byte;
              expected_reply_next = item.tx_byte ^ kbl_pkg::INV_MASK;
              byte_position_next  = 8'd1;
              phase_next          = kbl_pkg::PH_TXWAIT;
            end
          end

          kbl_pkg::PH_TXHOST: begin
            result.tx_valid     = 1'b1;
            result.tx_out       = send_byte;
            result.status       = kbl_pkg::ST_BUSY;
            expected_reply_next = send_byte ^ kbl_pkg::INV_MASK;
            byte_position_next  = byte_position + 8'd1;
            phase_next          = kbl_pkg::PH_TXWAIT;
          end

          default: ;
        endcase
      end

      default: ;
    endcase
  end

  // State register, updated once per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= kbl_pkg::PH_IDLE;
      sync_position  <= '0;
      block_count    <= '0;
      byte_position  <= '0;
      block_length   <= '0;
      expected_reply <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      sync_position  <= sync_position_next;
      block_count    <= block_count_next;
      byte_position  <= byte_position_next;
      block_length   <= block_length_next;
      expected_reply <= expected_reply_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/kbl_out_reg.sv =====
// ----------------------------------------------------------------------------
// kbl_out_reg
// Result register with valid/ready toward the master side.
// ----------------------------------------------------------------------------
`default_nettype none

module kbl_out_reg (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         load,
  input  wire kbl_pkg::result_t  result,
  output logic              full,
  input  wire logic         take,
  output kbl_pkg::result_t  held
);

  // Valid flag: set on load, cleared when taken without a new load
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/kbl_checker.sv =====
// ----------------------------------------------------------------------------
// kbl_checker
// Port-level checks of the block link unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "kw1281_block_link_unit_assert.svh"

module kbl_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [1:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata,
  input wire logic [6:0]  m_tuser
);

  // held result does not change while stalled
  `KBL_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // no transmit means a zero transmit byte
  `KBL_ASSERT_NOW(a_tx_zero, clk, rst, m_tvalid && !m_tdata[0], m_tdata[8:1] == 8'd0)

  // no field kind means a zero value
  `KBL_ASSERT_NOW(a_rx_zero, clk, rst, m_tvalid && (m_tuser[2:0] == kbl_pkg::FLD_NONE), m_tdata[16:9] == 8'd0)

  // a start beat gives a busy result with nothing to send next cycle
  `KBL_ASSERT_NEXT(a_start, clk, rst, s_tvalid && s_tready && (s_tuser == kbl_pkg::REQ_START), m_tvalid && (m_tuser[6:3] == kbl_pkg::ST_BUSY) && !m_tdata[0])

  // an unexpected request never transmits
  `KBL_ASSERT_NOW(a_unexp, clk, rst, m_tvalid && (m_tuser[6:3] == kbl_pkg::ST_UNEXPECTED), !m_tdata[0])

endmodule

bind kw1281_block_link_unit kbl_checker u_kbl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
